// ===== sv/psched_pkg.sv =====
`default_nettype none
package psched_pkg;

	localparam int NUM_SLOTS = 8;
	localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W     = 64;
	localparam int PER_W     = 16;
	localparam int MASK_W    = 8;
	localparam int RSLOT_W   = 3;
	localparam int BITS_W    = $clog2(CNT_W + 1);

	localparam logic MODE_TICK = 1'b0;
	localparam logic MODE_REG  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_NEXT,
		ST_DONE
	} state_t;

	// first free slot
	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] idx;
	} free_t;

	// remainder unit status
	typedef struct packed {
		logic done;
		logic zero;
	} rem_t;

endpackage
`default_nettype wire

// ===== sv/psched_rem.sv =====
`default_nettype none
module psched_rem
	import psched_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire logic [CNT_W-1:0] dividend,
	input  wire logic [PER_W-1:0] divisor,
	output rem_t                  stat
);

	logic [CNT_W-1:0]  sh_q;
	logic [PER_W-1:0]  rem_q;
	logic [BITS_W-1:0] cnt_q;
	logic              run_q;
	logic              done_q;
	logic [PER_W:0]    trial;
	logic [PER_W:0]    diff;
	logic              ge;

	// restoring division, one dividend bit per cycle, MSB first
	always_comb begin
		trial = {rem_q, sh_q[CNT_W-1]};
		diff  = trial - {1'b0, divisor};
		ge    = trial >= {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				run_q <= 1'b1;
				cnt_q <= BITS_W'(CNT_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == BITS_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sh_q  <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			sh_q  <= {sh_q[CNT_W-2:0], 1'b0};
			rem_q <= ge ? diff[PER_W-1:0] : trial[PER_W-1:0];
		end
	end

	assign stat.done = done_q;
	assign stat.zero = (rem_q == '0);

endmodule
`default_nettype wire

// ===== sv/psched_table.sv =====
`default_nettype none
module psched_table
	import psched_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire logic [PER_W-1:0]  wr_period,
	input  wire logic              wr_svc,
	input  wire logic [SLOT_W-1:0] rd_idx,
	output logic      [PER_W-1:0]  rd_period,
	output logic                   rd_svc,
	output free_t                  free
);

	logic [PER_W-1:0] period_q [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] svc_q;

	// lowest free slot wins
	always_comb begin
		free = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (period_q[i] == '0) begin
				free.found = 1'b1;
				free.idx   = SLOT_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				period_q[i] <= '0;
			end
			svc_q <= '0;
		end else if (wr_en && free.found) begin
			period_q[free.idx] <= wr_period;
			svc_q[free.idx]    <= wr_svc;
		end
	end

	assign rd_period = period_q[rd_idx];
	assign rd_svc    = svc_q[rd_idx];

endmodule
`default_nettype wire

// ===== sv/periodic_service_scheduler_core.sv =====
// Register word: done strobes in the cycle after start is taken.
// Tick word: done strobes after start once every slot has been checked in turn;
// each slot takes a load state, a bit-serial remainder of the 64-bit tick count by its period, then a next state.
// One word at a time: busy stays high through the done cycle, so a new word is taken
// only after the scheduler is back in idle; the receiver cannot stall.
// Asynchronous reset (arst_n low) clears the tick counter and frees every slot.
`default_nettype none
module periodic_service_scheduler_core
	import psched_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               mode,
	input  wire logic [PER_W-1:0]   period,
	input  wire logic               has_service,
	input  wire logic               has_init,
	output logic                    done,
	output logic [MASK_W-1:0]       due_mask,
	output logic                    reg_ok,
	output logic [RSLOT_W-1:0]      reg_slot,
	output logic                    init_request
);

	state_t             state_q;
	state_t             state_d;
	logic [SLOT_W-1:0]  slot_q;
	logic [CNT_W-1:0]   count_q;
	logic [MASK_W-1:0]  mask_q;
	logic               ok_q;
	logic [RSLOT_W-1:0] rslot_q;
	logic               req_q;

	logic               accept;
	logic               rem_load;
	logic               tbl_wr;
	logic               last_slot;
	logic               hit;
	logic [PER_W-1:0]   rd_period;
	logic               rd_svc;
	free_t              free;
	rem_t               rem;

	psched_table u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (tbl_wr),
		.wr_period (period),
		.wr_svc    (has_service),
		.rd_idx    (slot_q),
		.rd_period (rd_period),
		.rd_svc    (rd_svc),
		.free      (free)
	);

	psched_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (rem_load),
		.dividend (count_q),
		.divisor  (rd_period),
		.stat     (rem)
	);

	assign accept    = start && !busy;
	assign last_slot = (slot_q == SLOT_W'(NUM_SLOTS - 1));
	assign hit       = (rd_period != '0) && rd_svc && rem.zero;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (mode == MODE_REG) ? ST_DONE : ST_LOAD;
				end
			end
			ST_LOAD: state_d = ST_DIV;
			ST_DIV: begin
				if (rem.done) begin
					state_d = ST_NEXT;
				end
			end
			ST_NEXT: state_d = last_slot ? ST_DONE : ST_LOAD;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy     = (state_q != ST_IDLE);
		done     = (state_q == ST_DONE);
		rem_load = (state_q == ST_LOAD);
		tbl_wr   = accept && (mode == MODE_REG);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			slot_q  <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				slot_q <= '0;
				if (mode == MODE_TICK) begin
					count_q <= count_q + 1'b1;
				end
			end else if (state_q == ST_NEXT) begin
				slot_q <= slot_q + 1'b1;
			end
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (accept) begin
			mask_q <= '0;
			if (mode == MODE_REG && free.found) begin
				ok_q    <= 1'b1;
				rslot_q <= RSLOT_W'(free.idx);
				req_q   <= has_init;
			end else begin
				ok_q    <= 1'b0;
				rslot_q <= '0;
				req_q   <= 1'b0;
			end
		end else if (state_q == ST_NEXT && hit) begin
			for (int i = 0; i < MASK_W; i++) begin
				if (i < NUM_SLOTS && slot_q == SLOT_W'(i)) begin
					mask_q[i] <= 1'b1;
				end
			end
		end
	end

	assign due_mask     = mask_q;
	assign reg_ok       = ok_q;
	assign reg_slot     = rslot_q;
	assign init_request = req_q;

endmodule
`default_nettype wire
